// ===== hdl/spnt_pkg.sv =====
// package for the sorted phone number table
// item types, command and status codes, cell control struct; no dependencies
`timescale 1ns / 1ps

package spnt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int TAG_BITS    = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 34;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_READ   = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_EMPTY_SLOT = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [9:0]  area_code;
        logic [9:0]  exchange_code;
        logic [13:0] line_number;
        logic [15:0] record_tag;
        logic [5:0]  slot_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  placed_index;
        logic [9:0]  area_out;
        logic [9:0]  exchange_out;
        logic [13:0] line_out;
        logic [15:0] tag_out;
        logic [6:0]  entry_count;
    } out_item_t;

    // broadcast to every cell in the execute cycle
    typedef struct packed {
        logic                ins;
        logic                del;
        logic                front;
        logic [KEY_W-1:0]    key;
        logic [TAG_BITS-1:0] tag;
        logic [IDX_W-1:0]    slot;
        logic [CNT_W-1:0]    count;
    } cell_op_t;

endpackage

// ===== hdl/spnt_cell.sv =====
// one record cell of the sorted table chain
// holds a key and tag, compares against the broadcast key and shifts with its neighbors
// depends on spnt_pkg
`timescale 1ns / 1ps

module spnt_cell (
    input  logic                         clk,
    input  logic [spnt_pkg::IDX_W-1:0]   idx,
    input  spnt_pkg::cell_op_t           op,
    input  logic [spnt_pkg::KEY_W-1:0]   prev_key,
    input  logic [spnt_pkg::TAG_BITS-1:0] prev_tag,
    input  logic                         prev_occ,
    input  logic                         prev_lt,
    input  logic [spnt_pkg::KEY_W-1:0]   next_key,
    input  logic [spnt_pkg::TAG_BITS-1:0] next_tag,
    input  logic                         next_occ,
    output logic [spnt_pkg::KEY_W-1:0]   key,
    output logic [spnt_pkg::TAG_BITS-1:0] tag,
    output logic                         occ,
    output logic                         lt,
    output logic                         take
);
    import spnt_pkg::*;

    logic [KEY_W-1:0]    key_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic                first_cell;
    logic                shift_in;
    logic                shift_out;

    assign key        = key_reg;
    assign tag        = tag_reg;
    assign occ        = {1'b0, idx} < op.count;
    assign lt         = key_reg < op.key;
    assign first_cell = (idx == '0);

    always_comb
    begin
        if (op.front)
        begin
            take     = op.ins && first_cell;
            shift_in = op.ins && prev_occ;
        end
        else
        begin
            take     = op.ins && prev_occ && ((idx == IDX_W'(1)) || prev_lt) && !(occ && lt);
            shift_in = op.ins && prev_occ && (idx > IDX_W'(1)) && !prev_lt;
        end
        shift_out = op.del && (idx >= op.slot) && next_occ;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            key_reg <= op.key;
            tag_reg <= op.tag;
        end
        else if (shift_in)
        begin
            key_reg <= prev_key;
            tag_reg <= prev_tag;
        end
        else if (shift_out)
        begin
            key_reg <= next_key;
            tag_reg <= next_tag;
        end
    end

endmodule

// ===== hdl/sorted_phone_number_table.sv =====
// sorted phone number table, top level: command register, cell chain, result register
// depends on spnt_pkg and spnt_cell
//
//   port group                   flow        handshake
//   item_valid/item_stall/item   into block  accepted when item_valid && !item_stall
//   result_valid/result_stall/result  out    taken when result_valid && !result_stall
//
// every command is first latched into the command register, then executes once the result
// register is free or being taken: all cells compare and shift together and the result register loads
// the next item is accepted as soon as the command register is free, even while
// a result waits; reset empties the table at once (no clearing pass)
`timescale 1ns / 1ps

module sorted_phone_number_table (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  spnt_pkg::in_item_t   item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output spnt_pkg::out_item_t  result
);
    import spnt_pkg::*;

    in_item_t            cmd_reg;
    logic                busy_reg;
    logic                busy_next;
    out_item_t           result_reg;
    out_item_t           result_next;
    logic                result_valid_reg;
    logic                result_valid_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    logic                exec;
    logic                full;
    logic                slot_ok;
    cell_op_t            op;

    logic [KEY_W-1:0]    cell_key [TABLE_DEPTH];
    logic [TAG_BITS-1:0] cell_tag [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] cell_occ;
    logic [TABLE_DEPTH-1:0] cell_lt;
    logic [TABLE_DEPTH-1:0] cell_take;

    logic [IDX_W-1:0]    placed;
    logic [KEY_W-1:0]    rd_key;
    logic [TAG_BITS-1:0] rd_tag;

    assign item_stall   = busy_reg;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign exec    = busy_reg && (!result_valid_reg || !result_stall);
    assign full    = (count_reg == CNT_W'(TABLE_DEPTH));
    assign slot_ok = {1'b0, cmd_reg.slot_index} < count_reg;

    always_comb
    begin
        op.ins   = exec && (cmd_reg.cmd == CMD_INSERT) && !full;
        op.del   = exec && (cmd_reg.cmd == CMD_DELETE) && slot_ok;
        // new key strictly below the first stored key, or any key into an empty table, goes to the front
        op.front = (count_reg == '0) ||
                   ({cmd_reg.area_code, cmd_reg.exchange_code, cmd_reg.line_number}
                    < cell_key[0]);
        op.key   = {cmd_reg.area_code, cmd_reg.exchange_code, cmd_reg.line_number};
        op.tag   = cmd_reg.record_tag;
        op.slot  = cmd_reg.slot_index;
        op.count = count_reg;
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            logic [KEY_W-1:0]    pk;
            logic [TAG_BITS-1:0] pt;
            logic                po;
            logic                pl;
            logic [KEY_W-1:0]    nk;
            logic [TAG_BITS-1:0] nt;
            logic                no;

            if (g == 0)
            begin : g_first
                assign pk = '0;
                assign pt = '0;
                assign po = 1'b0;
                assign pl = 1'b0;
            end
            else
            begin : g_mid
                assign pk = cell_key[g-1];
                assign pt = cell_tag[g-1];
                assign po = cell_occ[g-1];
                assign pl = cell_lt[g-1];
            end

            if (g == TABLE_DEPTH - 1)
            begin : g_last
                assign nk = '0;
                assign nt = '0;
                assign no = 1'b0;
            end
            else
            begin : g_inner
                assign nk = cell_key[g+1];
                assign nt = cell_tag[g+1];
                assign no = cell_occ[g+1];
            end

            spnt_cell u_cell (
                .clk      (clk),
                .idx      (IDX_W'(g)),
                .op       (op),
                .prev_key (pk),
                .prev_tag (pt),
                .prev_occ (po),
                .prev_lt  (pl),
                .next_key (nk),
                .next_tag (nt),
                .next_occ (no),
                .key      (cell_key[g]),
                .tag      (cell_tag[g]),
                .occ      (cell_occ[g]),
                .lt       (cell_lt[g]),
                .take     (cell_take[g])
            );
        end
    endgenerate

    // position of the taking cell and the cell at the slot
    always_comb
    begin
        placed = '0;
        rd_key = '0;
        rd_tag = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (cell_take[i])
            begin
                placed = placed | IDX_W'(i);
            end
            if (cmd_reg.slot_index == IDX_W'(i))
            begin
                rd_key = rd_key | cell_key[i];
                rd_tag = rd_tag | cell_tag[i];
            end
        end
    end

    always_comb
    begin
        busy_next         = busy_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        count_next        = count_reg;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        if (exec)
        begin
            busy_next         = 1'b0;
            result_valid_next = 1'b1;
            result_next       = '0;
            case (cmd_t'(cmd_reg.cmd))
                CMD_INSERT:
                begin
                    if (full)
                    begin
                        result_next.status = ST_FULL;
                    end
                    else
                    begin
                        result_next.status       = ST_OK;
                        result_next.placed_index = 6'(placed);
                        count_next               = count_reg + CNT_W'(1);
                    end
                end
                CMD_READ, CMD_DELETE:
                begin
                    result_next.placed_index = cmd_reg.slot_index;
                    if (!slot_ok)
                    begin
                        result_next.status = ST_EMPTY_SLOT;
                    end
                    else
                    begin
                        result_next.status  = ST_OK;
                        result_next.tag_out = 16'(rd_tag);
                        if (cmd_reg.cmd == CMD_READ)
                        begin
                            result_next.area_out     = rd_key[33:24];
                            result_next.exchange_out = rd_key[23:14];
                            result_next.line_out     = rd_key[13:0];
                        end
                        else
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                end
                default:
                begin
                    result_next.status = ST_OK;
                    count_next         = '0;
                end
            endcase
            result_next.entry_count = 7'(count_next);
        end

        if (item_valid && !item_stall)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            count_reg        <= '0;
        end
        else
        begin
            busy_reg         <= busy_next;
            result_valid_reg <= result_valid_next;
            count_reg        <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            cmd_reg <= item;
        end
        result_reg <= result_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_single_take: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_take))
        else $error("more than one cell takes the new record");

    a_take_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
        op.ins |-> $onehot(cell_take))
        else $error("insert without exactly one taking cell");

    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        exec |=> result_valid_reg && !busy_reg)
        else $error("executed command left no result");

    a_count_stable_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !exec |=> $stable(count_reg))
        else $error("entry count changed outside execute");

endmodule
